### rtl/core/led_sparkle_fader_assert.svh
// ----------------------------------------------------------------------------
// led_sparkle_fader assertion macros
// Clocked property wrappers shared by the port checker.
// ----------------------------------------------------------------------------
`ifndef LED_SPARKLE_FADER_ASSERT_SVH
`define LED_SPARKLE_FADER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LSF_ASSERT_SAME(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("lsf assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define LSF_ASSERT_NEXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("lsf assertion failed");

`endif

### rtl/core/lsf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsf_pkg
// Shared constants and types of the LED sparkle fader.
// ----------------------------------------------------------------------------
package lsf_pkg;

    localparam int NUM_LEDS     = 64;
    localparam int PALETTE_SIZE = 16;

    localparam int OP_W     = 2;
    localparam int LED_W    = 6;
    localparam int SLOT_W   = 4;
    localparam int CHAN_W   = 8;
    localparam int COLOR_W  = 3 * CHAN_W;
    localparam int DELTA_W  = 10;
    localparam int RAND_W   = 16;
    localparam int SPEED_W  = 8;
    localparam int BRIGHT_W = 11;
    localparam int STEP_W   = 13;
    localparam int PAUSE_W  = 10;
    localparam int PROD_W   = SPEED_W + DELTA_W;

    localparam int S_DATA_W = 96;
    localparam int M_DATA_W = 32;

    localparam int CFG_AW = 3;
    localparam int CFG_DW = 32;

    // Operation codes carried on tuser
    localparam logic [OP_W-1:0] OP_PAL_WRITE = 2'd0;
    localparam logic [OP_W-1:0] OP_LED_INIT  = 2'd1;
    localparam logic [OP_W-1:0] OP_LED_TICK  = 2'd2;

    // Register indexes
    localparam logic REG_FADE_IN  = 1'b0;
    localparam logic REG_FADE_OUT = 1'b1;

    localparam logic [SPEED_W-1:0] FADE_IN_RESET  = 8'd30;
    localparam logic [SPEED_W-1:0] FADE_OUT_RESET = 8'd6;

    localparam int STEP_PERIOD_MS = 50;
    localparam int PAUSE_RANGE    = 800;
    localparam int FULL_BRIGHT    = 255;

    // x / 50 = (x >> 1) / 25, with (x >> 1) below 2^17
    localparam int                 STEP_RECIP_SH  = 22;
    localparam logic [17:0]        STEP_RECIP_MUL = 18'd167773;
    // x / 800 = (x >> 5) / 25, with (x >> 5) below 2^11
    localparam int                 PAUSE_RECIP_SH  = 16;
    localparam logic [11:0]        PAUSE_RECIP_MUL = 12'd2622;
    localparam int                 PAUSE_Q_W       = 7;

    // Command queue
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    typedef struct packed {
        logic [OP_W-1:0]     op;
        logic [LED_W-1:0]    led;
        logic [SLOT_W-1:0]   pslot;
        logic [COLOR_W-1:0]  color;
        logic [STEP_W-1:0]   step_in;
        logic [STEP_W-1:0]   step_out;
        logic [PAUSE_W-1:0]  pause;
        logic [BRIGHT_W-1:0] init_bright;
        logic [SLOT_W-1:0]   init_slot;
        logic [SLOT_W-1:0]   reseed_slot;
    } cmd_t;

    typedef struct packed {
        logic              empty;
        logic [Q_CW-1:0]   count;
    } q_status_t;

    typedef struct packed {
        logic [BRIGHT_W-1:0] bright;
        logic                rising;
        logic [SLOT_W-1:0]   slot;
    } led_state_t;

endpackage

### rtl/core/lsf_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsf_front
// Accepts beats, drops unused codes and precomputes fade steps and reseeds.
// ----------------------------------------------------------------------------
module lsf_front
    import lsf_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [OP_W-1:0]     s_tuser,
    input  logic [S_DATA_W-1:0] s_tdata,
    input  logic [SPEED_W-1:0]  fade_in_speed,
    input  logic [SPEED_W-1:0]  fade_out_speed,
    input  q_status_t           q_status,
    output logic                push,
    output cmd_t                push_cmd
);

    logic                accept;
    logic                op_known;
    logic [LED_W-1:0]    in_led;
    logic [SLOT_W-1:0]   in_pslot;
    logic [COLOR_W-1:0]  in_color;
    logic [DELTA_W-1:0]  in_delta;
    logic [RAND_W-1:0]   in_ra;
    logic [RAND_W-1:0]   in_rb;
    logic [RAND_W-1:0]   in_rc;
    logic [22:0]         qa_prod;
    logic [PROD_W-1:0]   p_in;
    logic [PROD_W-1:0]   p_out;
    logic [34:0]         step_in_prod;
    logic [34:0]         step_out_prod;

    logic                f1_valid_reg;
    logic [OP_W-1:0]     f1_op_reg;
    logic [LED_W-1:0]    f1_led_reg;
    logic [SLOT_W-1:0]   f1_pslot_reg;
    logic [COLOR_W-1:0]  f1_color_reg;
    logic [PROD_W-1:0]   f1_p_in_reg;
    logic [PROD_W-1:0]   f1_p_out_reg;
    logic [PAUSE_Q_W-1:0] f1_qa_reg;
    logic [PAUSE_W-1:0]  f1_ra_low_reg;
    logic [BRIGHT_W-1:0] f1_init_bright_reg;
    logic [SLOT_W-1:0]   f1_init_slot_reg;
    logic [SLOT_W-1:0]   f1_reseed_slot_reg;

    assign in_led   = s_tdata[5:0];
    assign in_pslot = s_tdata[9:6];
    // red in the top byte, blue in the bottom byte
    assign in_color = {s_tdata[17:10], s_tdata[25:18], s_tdata[33:26]};
    assign in_delta = s_tdata[43:34];
    assign in_ra    = s_tdata[59:44];
    assign in_rb    = s_tdata[75:60];
    assign in_rc    = s_tdata[91:76];

    // Leave room in the queue for the beat in the stage register
    assign s_tready = ({1'b0, q_status.count} + (Q_CW + 1)'(f1_valid_reg))
                      < (Q_CW + 1)'(Q_DEPTH);
    assign accept   = s_tvalid && s_tready;
    assign op_known = s_tuser inside {OP_PAL_WRITE, OP_LED_INIT, OP_LED_TICK};

    assign p_in    = fade_in_speed * in_delta;
    assign p_out   = fade_out_speed * in_delta;
    assign qa_prod = in_ra[15:5] * PAUSE_RECIP_MUL;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f1_valid_reg <= 1'b0;
        end else begin
            f1_valid_reg <= accept && op_known;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            f1_op_reg          <= s_tuser;
            f1_led_reg         <= in_led;
            f1_pslot_reg       <= in_pslot;
            f1_color_reg       <= in_color;
            f1_p_in_reg        <= p_in;
            f1_p_out_reg       <= p_out;
            f1_qa_reg          <= qa_prod[22:PAUSE_RECIP_SH];
            f1_ra_low_reg      <= in_ra[PAUSE_W-1:0];
            f1_init_bright_reg <= {3'b000, in_rb[7:0]} - {3'b000, in_ra[7:0]};
            f1_init_slot_reg   <= in_rc[SLOT_W-1:0];
            f1_reseed_slot_reg <= in_rb[SLOT_W-1:0];
        end
    end

    // Divide the products by the step period through reciprocals
    assign step_in_prod  = f1_p_in_reg[PROD_W-1:1] * STEP_RECIP_MUL;
    assign step_out_prod = f1_p_out_reg[PROD_W-1:1] * STEP_RECIP_MUL;

    assign push = f1_valid_reg;

    always_comb begin
        push_cmd.op          = f1_op_reg;
        push_cmd.led         = f1_led_reg;
        push_cmd.pslot       = f1_pslot_reg;
        push_cmd.color       = f1_color_reg;
        push_cmd.step_in     = step_in_prod[STEP_RECIP_SH +: STEP_W];
        push_cmd.step_out    = step_out_prod[STEP_RECIP_SH +: STEP_W];
        // remainder stays below 800, so the low bits suffice
        push_cmd.pause       = f1_ra_low_reg - PAUSE_W'(f1_qa_reg * PAUSE_RANGE);
        push_cmd.init_bright = f1_init_bright_reg;
        push_cmd.init_slot   = f1_init_slot_reg;
        push_cmd.reseed_slot = f1_reseed_slot_reg;
    end

endmodule

### rtl/core/lsf_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsf_queue
// Short command queue between the front and the back end.
// ----------------------------------------------------------------------------
module lsf_queue
    import lsf_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push,
    input  cmd_t      push_cmd,
    input  logic      pop,
    output cmd_t      head,
    output q_status_t status
);

    cmd_t            entry_reg [Q_DEPTH];
    logic [Q_AW-1:0] wr_ptr_reg;
    logic [Q_AW-1:0] rd_ptr_reg;
    logic [Q_CW-1:0] count_reg;
    logic [Q_CW-1:0] count_next;

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (!push && pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    assign head         = entry_reg[rd_ptr_reg];
    assign status.empty = (count_reg == '0);
    assign status.count = count_reg;

endmodule

### rtl/core/lsf_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsf_back
// LED state read-modify-write, palette store, color scaling and output beat.
// ----------------------------------------------------------------------------
module lsf_back
    import lsf_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  q_status_t           q_status,
    input  cmd_t                q_head,
    output logic                pop,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata
);

    logic                 advance;

    // LED state memory, registered read
    led_state_t           led_mem [NUM_LEDS];
    led_state_t           rd_data_reg;

    logic                 b1_valid_reg;
    cmd_t                 b1_cmd_reg;

    // Most recent state write, for the back-to-back same-LED case
    logic                 lw_valid_reg;
    logic [LED_W-1:0]     lw_idx_reg;
    led_state_t           lw_state_reg;

    logic [COLOR_W-1:0]   palette_reg [PALETTE_SIZE];

    led_state_t           cur_state;
    led_state_t           new_state;
    logic signed [13:0]   cur_ext;
    logic signed [13:0]   rise_sum;
    logic signed [13:0]   fall_diff;
    logic                 mem_we;
    logic                 pal_we;
    logic                 lit;

    logic                 b2_valid_reg;
    logic [LED_W-1:0]     b2_led_reg;
    logic [CHAN_W-1:0]    b2_level_reg;
    logic [COLOR_W-1:0]   b2_color_reg;

    logic [15:0]          prod_r;
    logic [15:0]          prod_g;
    logic [15:0]          prod_b;
    logic [16:0]          sum_r;
    logic [16:0]          sum_g;
    logic [16:0]          sum_b;

    logic                 m_valid_reg;
    logic [M_DATA_W-1:0]  m_data_reg;

    assign advance = !m_valid_reg || m_tready;
    assign pop     = advance && !q_status.empty;

    always_ff @(posedge aclk) begin
        if (pop) begin
            rd_data_reg <= led_mem[q_head.led];
        end
        if (mem_we) begin
            led_mem[b1_cmd_reg.led] <= new_state;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b1_valid_reg <= 1'b0;
            lw_valid_reg <= 1'b0;
            b2_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (advance) begin
                b1_valid_reg <= pop;
                b2_valid_reg <= b1_valid_reg && (b1_cmd_reg.op == OP_LED_TICK);
                m_valid_reg  <= b2_valid_reg;
            end
            if (mem_we) begin
                lw_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            b1_cmd_reg <= q_head;
        end
        if (mem_we) begin
            lw_idx_reg   <= b1_cmd_reg.led;
            lw_state_reg <= new_state;
        end
        if (pal_we) begin
            palette_reg[b1_cmd_reg.pslot] <= b1_cmd_reg.color;
        end
    end

    // Take the forwarded state when the previous write hit the same LED
    assign cur_state = (lw_valid_reg && (lw_idx_reg == b1_cmd_reg.led)) ?
                       lw_state_reg : rd_data_reg;

    assign cur_ext   = 14'(signed'(cur_state.bright));
    assign rise_sum  = cur_ext + $signed({1'b0, b1_cmd_reg.step_in});
    assign fall_diff = cur_ext - $signed({1'b0, b1_cmd_reg.step_out});

    always_comb begin
        new_state = cur_state;
        if (b1_cmd_reg.op == OP_LED_INIT) begin
            new_state.bright = b1_cmd_reg.init_bright;
            new_state.rising = 1'b1;
            new_state.slot   = b1_cmd_reg.init_slot;
        end else if (cur_state.rising) begin
            if (rise_sum > $signed(14'(FULL_BRIGHT))) begin
                // clamp at full and turn around
                new_state.bright = BRIGHT_W'(FULL_BRIGHT);
                new_state.rising = 1'b0;
            end else begin
                new_state.bright = rise_sum[BRIGHT_W-1:0];
            end
        end else begin
            if (fall_diff[13]) begin
                // reseed with a dark pause and a new color
                new_state.bright = BRIGHT_W'(0) - {1'b0, b1_cmd_reg.pause};
                new_state.rising = 1'b1;
                new_state.slot   = b1_cmd_reg.reseed_slot;
            end else begin
                new_state.bright = fall_diff[BRIGHT_W-1:0];
            end
        end
    end

    assign mem_we = advance && b1_valid_reg &&
                    ((b1_cmd_reg.op == OP_LED_INIT) || (b1_cmd_reg.op == OP_LED_TICK));
    assign pal_we = advance && b1_valid_reg && (b1_cmd_reg.op == OP_PAL_WRITE);

    assign lit = !new_state.bright[BRIGHT_W-1] && (new_state.bright != '0);

    always_ff @(posedge aclk) begin
        if (advance) begin
            b2_led_reg   <= b1_cmd_reg.led;
            b2_level_reg <= lit ? new_state.bright[CHAN_W-1:0] : '0;
            b2_color_reg <= palette_reg[new_state.slot];
        end
    end

    // p / 255 == (p + (p >> 8) + 1) >> 8 for 8 by 8 bit products
    assign prod_r = b2_level_reg * b2_color_reg[23:16];
    assign prod_g = b2_level_reg * b2_color_reg[15:8];
    assign prod_b = b2_level_reg * b2_color_reg[7:0];
    assign sum_r  = {1'b0, prod_r} + {9'd0, prod_r[15:8]} + 17'd1;
    assign sum_g  = {1'b0, prod_g} + {9'd0, prod_g[15:8]} + 17'd1;
    assign sum_b  = {1'b0, prod_b} + {9'd0, prod_b[15:8]} + 17'd1;

    always_ff @(posedge aclk) begin
        if (advance && b2_valid_reg) begin
            m_data_reg <= {2'b00, sum_b[15:8], sum_g[15:8], sum_r[15:8], b2_led_reg};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

### rtl/core/led_sparkle_fader.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_sparkle_fader
// Per-LED sparkle engine: palette writes, LED seeding and fade ticks.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats carry the operation code on s_tuser (palette write, LED
//   initialize, LED tick) and the operands on s_tdata. Unused codes are
//   accepted and dropped. Only a tick produces an output beat: the LED
//   index and its scaled red, green and blue drive values.
//   The two fade speeds sit on the APB port at byte addresses 0 and 4;
//   write them only while no beat is in flight.
// Timing:
//   One beat per cycle in and out, sustained while m_tready is high. A tick
//   reaches m_tvalid through the front stage, the queue, the state read, the
//   color stage and the output register. The LED state memory sets the pace:
//   one read and one write a cycle, a write forwarded to a same-LED tick behind it.
// Reset:
//   aresetn (synchronous, active low) empties the pipeline and the queue
//   and loads the fade speeds 30 and 6. LED states and palette entries hold
//   no reset value and must be written before they are read.
// Back-pressure:
//   While m_tready is low the back end holds its beats; the front end keeps
//   taking input until the four-entry command queue, with the beat in the front
//   stage register counted, is full, then drops s_tready.
// ----------------------------------------------------------------------------
module led_sparkle_fader
    import lsf_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    // input stream
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [OP_W-1:0]     s_tuser,   // [1:0] operation
    input  logic [S_DATA_W-1:0] s_tdata,   // [5:0] led_index, [9:6] palette_slot,
                                           // [17:10] color_red, [25:18] color_green,
                                           // [33:26] color_blue, [43:34] delta_ms,
                                           // [59:44] rand_a, [75:60] rand_b,
                                           // [91:76] rand_c, [95:92] zero
    // result stream
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,   // [5:0] led_out_index, [13:6] out_red,
                                           // [21:14] out_green, [29:22] out_blue,
                                           // [31:30] zero
    // configuration
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [CFG_AW-1:0]   paddr,
    input  logic [CFG_DW-1:0]   pwdata,
    output logic [CFG_DW-1:0]   prdata,
    output logic                pready
);

    logic [SPEED_W-1:0] fade_in_reg;
    logic [SPEED_W-1:0] fade_out_reg;
    logic               cfg_write;
    logic               reg_idx;

    logic               push;
    cmd_t               push_cmd;
    logic               pop;
    cmd_t               q_head;
    q_status_t          q_status;

    // Register file: word address selects the register
    assign pready    = 1'b1;
    assign reg_idx   = paddr[2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fade_in_reg  <= FADE_IN_RESET;
            fade_out_reg <= FADE_OUT_RESET;
        end else if (cfg_write) begin
            case (reg_idx)
                REG_FADE_IN:  fade_in_reg  <= pwdata[SPEED_W-1:0];
                REG_FADE_OUT: fade_out_reg <= pwdata[SPEED_W-1:0];
                default:      fade_in_reg  <= fade_in_reg;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_FADE_IN:  prdata = {{(CFG_DW - SPEED_W){1'b0}}, fade_in_reg};
            REG_FADE_OUT: prdata = {{(CFG_DW - SPEED_W){1'b0}}, fade_out_reg};
            default:      prdata = '0;
        endcase
    end

    // Front end: accept, drop unused codes, precompute steps and reseeds
    lsf_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tuser        (s_tuser),
        .s_tdata        (s_tdata),
        .fade_in_speed  (fade_in_reg),
        .fade_out_speed (fade_out_reg),
        .q_status       (q_status),
        .push           (push),
        .push_cmd       (push_cmd)
    );

    // Decouple the two halves so each can stall on its own
    lsf_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (q_head),
        .status   (q_status)
    );

    // Back end: LED state update, palette lookup, scaling, output beat
    lsf_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_status (q_status),
        .q_head   (q_head),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

### rtl/core/lsf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsf_checker
// Port-level checks of the LED sparkle fader, bound to the top level.
// ----------------------------------------------------------------------------
`include "led_sparkle_fader_assert.svh"

module lsf_checker
    import lsf_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                s_tready,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata,
    input logic                psel,
    input logic                penable,
    input logic                pwrite,
    input logic [CFG_AW-1:0]   paddr,
    input logic [CFG_DW-1:0]   pwdata,
    input logic [CFG_DW-1:0]   prdata,
    input logic                pready
);

    logic              in_rd;
    logic              in_wr;
    logic [CFG_DW-1:0] in_wdata;

    // Fade-in register selected, and a completed write to it
    assign in_rd    = (paddr[2] == REG_FADE_IN);
    assign in_wr    = aresetn && psel && penable && pwrite && pready && in_rd;
    assign in_wdata = {{(CFG_DW - SPEED_W){1'b0}}, pwdata[SPEED_W-1:0]};

    // Stalled result beat stays up and unchanged
    `LSF_ASSERT_NEXT(a_out_hold_valid, aclk, aresetn, m_tvalid && !m_tready, m_tvalid)
    `LSF_ASSERT_NEXT(a_out_hold_data, aclk, aresetn, m_tvalid && !m_tready, $stable(m_tdata))

    // Leaving reset: no stale result, room for input
    `LSF_ASSERT_SAME(a_reset_clean, aclk, aresetn, $past(!aresetn), !m_tvalid && s_tready)

    // A fade-in write reads back on the next cycle, upper bits zero
    `LSF_ASSERT_SAME(a_cfg_readback, aclk, aresetn, $past(in_wr) && in_rd, prdata == $past(in_wdata))

endmodule

bind led_sparkle_fader lsf_checker u_lsf_checker (.*);

### verif/led_sparkle_fader_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_sparkle_fader_tb
// Self-checking regression for the LED sparkle fader.
// ----------------------------------------------------------------------------
// A queue of commands (palette writes, LED seeds, ticks and dropped codes)
// feeds a stream driver; a monitor on the same clock predicts every color
// beat from its own copy of the LED and palette state and checks each output
// beat field by field. The run walks through several fade speed settings,
// extremes among them, and three back-pressure profiles. Only seeded LEDs
// are ticked and only written palette slots are ever selected.
// ----------------------------------------------------------------------------
module led_sparkle_fader_tb;
    import lsf_pkg::*;

    // Operation code with no package name: the block drops it
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    localparam int WATCHDOG_LIMIT = 2000;
    // Pipeline latency plus queue depth, with margin
    localparam int SETTLE_CYCLES  = 16;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [LED_W-1:0]   led;
        logic [SLOT_W-1:0]  pslot;
        logic [CHAN_W-1:0]  red;
        logic [CHAN_W-1:0]  green;
        logic [CHAN_W-1:0]  blue;
        logic [DELTA_W-1:0] delta;
        logic [RAND_W-1:0]  rand_a;
        logic [RAND_W-1:0]  rand_b;
        logic [RAND_W-1:0]  rand_c;
    } sparkle_cmd_t;

    typedef struct packed {
        logic [LED_W-1:0]  led;
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } color_report_t;

    // ------------------------------------------------------------------
    // Clock, reset and block ports
    // ------------------------------------------------------------------
    logic                aclk    = 1'b0;
    logic                aresetn = 1'b0;

    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [OP_W-1:0]     s_tuser  = '0;   // [1:0] operation
    logic [S_DATA_W-1:0] s_tdata  = '0;   // [5:0] led_index, [9:6] palette_slot,
                                          // [17:10] color_red, [25:18] color_green,
                                          // [33:26] color_blue, [43:34] delta_ms,
                                          // [59:44] rand_a, [75:60] rand_b,
                                          // [91:76] rand_c, [95:92] zero
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;         // [5:0] led_out_index, [13:6] out_red,
                                          // [21:14] out_green, [29:22] out_blue,
                                          // [31:30] zero
    logic                psel    = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite  = 1'b0;
    logic [CFG_AW-1:0]   paddr   = '0;
    logic [CFG_DW-1:0]   pwdata  = '0;
    logic [CFG_DW-1:0]   prdata;
    logic                pready;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    led_sparkle_fader DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // ------------------------------------------------------------------
    // Predicted block state: fade speeds, per-LED level/direction/slot and
    // the palette. Updated in acceptance order, one command per input beat.
    // ------------------------------------------------------------------
    logic [SPEED_W-1:0]         fade_in_now  = FADE_IN_RESET;
    logic [SPEED_W-1:0]         fade_out_now = FADE_OUT_RESET;
    logic signed [BRIGHT_W-1:0] led_level [NUM_LEDS];
    logic                       led_up    [NUM_LEDS];
    logic [SLOT_W-1:0]          led_slot  [NUM_LEDS];
    logic [COLOR_W-1:0]         palette   [PALETTE_SIZE];

    // Generation-time bookkeeping: never read an unwritten LED or slot
    bit                led_seeded  [NUM_LEDS];
    bit                pal_written [PALETTE_SIZE];
    logic [SLOT_W-1:0] written_slots [$];

    sparkle_cmd_t  cmd_backlog [$];    // commands not yet accepted by the block
    color_report_t color_reports [$];  // color beats still owed by the block

    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    bit  beat_taken    = 1'b0;
    int  quiet_cycles  = 0;
    int  mismatches    = 0;
    int  n_pal = 0, n_init = 0, n_tick = 0, n_drop = 0, n_checked = 0;
    int  n_clamp = 0, n_reseed = 0, n_dark = 0, n_settings = 1;

    // ------------------------------------------------------------------
    // Predictor: apply one accepted command, queue the color beat a tick owes
    // ------------------------------------------------------------------
    function automatic int scale_chan(int level, logic [CHAN_W-1:0] chan);
        if (level <= 0)
            return 0;
        return (level * int'(chan)) / FULL_BRIGHT;
    endfunction

    function automatic void model_fader_beat(sparkle_cmd_t c);
        int                 level;
        int                 step;
        logic [COLOR_W-1:0] rgb;
        color_report_t      r;
        case (c.op)
            OP_PAL_WRITE: begin
                palette[c.pslot] = {c.red, c.green, c.blue};
                n_pal++;
            end
            OP_LED_INIT: begin
                led_level[c.led] = BRIGHT_W'(int'(c.rand_b[7:0]) - int'(c.rand_a[7:0]));
                led_up[c.led]    = 1'b1;
                led_slot[c.led]  = SLOT_W'(c.rand_c % PALETTE_SIZE);
                n_init++;
            end
            OP_LED_TICK: begin
                level = led_level[c.led];
                if (led_up[c.led]) begin
                    step  = (int'(fade_in_now) * int'(c.delta)) / STEP_PERIOD_MS;
                    level = level + step;
                    // Clamp at full brightness and turn around
                    if (level > FULL_BRIGHT) begin
                        level = FULL_BRIGHT;
                        led_up[c.led] = 1'b0;
                        n_clamp++;
                    end
                end else begin
                    step  = (int'(fade_out_now) * int'(c.delta)) / STEP_PERIOD_MS;
                    level = level - step;
                    // Dropped below zero: reseed with a dark pause and a new color
                    if (level < 0) begin
                        level = -int'(c.rand_a % PAUSE_RANGE);
                        led_up[c.led]   = 1'b1;
                        led_slot[c.led] = SLOT_W'(c.rand_b % PALETTE_SIZE);
                        n_reseed++;
                    end
                end
                led_level[c.led] = BRIGHT_W'(level);
                rgb     = palette[led_slot[c.led]];
                r.led   = c.led;
                r.red   = CHAN_W'(scale_chan(level, rgb[23:16]));
                r.green = CHAN_W'(scale_chan(level, rgb[15:8]));
                r.blue  = CHAN_W'(scale_chan(level, rgb[7:0]));
                if (level <= 0)
                    n_dark++;
                color_reports.push_back(r);
                n_tick++;
            end
            default: begin
                n_drop++;
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Stimulus construction
    // ------------------------------------------------------------------

    // Steer palette selections onto written slots, then queue the command
    function automatic void queue_cmd(sparkle_cmd_t c);
        if (c.op == OP_LED_INIT && !pal_written[c.rand_c[SLOT_W-1:0]])
            c.rand_c[SLOT_W-1:0] = written_slots[$urandom_range(written_slots.size() - 1)];
        if (c.op == OP_LED_TICK && !pal_written[c.rand_b[SLOT_W-1:0]])
            c.rand_b[SLOT_W-1:0] = written_slots[$urandom_range(written_slots.size() - 1)];
        if (c.op == OP_PAL_WRITE && !pal_written[c.pslot]) begin
            pal_written[c.pslot] = 1'b1;
            written_slots.push_back(c.pslot);
        end
        if (c.op == OP_LED_INIT)
            led_seeded[c.led] = 1'b1;
        cmd_backlog.push_back(c);
    endfunction

    function automatic sparkle_cmd_t fixed_cmd(logic [OP_W-1:0] op, logic [LED_W-1:0] led,
                                               logic [SLOT_W-1:0] pslot,
                                               logic [COLOR_W-1:0] rgb,
                                               logic [DELTA_W-1:0] delta,
                                               logic [RAND_W-1:0] ra, logic [RAND_W-1:0] rb,
                                               logic [RAND_W-1:0] rc);
        sparkle_cmd_t c;
        c.op     = op;
        c.led    = led;
        c.pslot  = pslot;
        c.red    = rgb[23:16];
        c.green  = rgb[15:8];
        c.blue   = rgb[7:0];
        c.delta  = delta;
        c.rand_a = ra;
        c.rand_b = rb;
        c.rand_c = rc;
        return c;
    endfunction

    // Mostly ticks on a handful of hot LEDs so they cycle through whole
    // fade-in, clamp, fade-out and reseed sequences; the rest is noise.
    function automatic sparkle_cmd_t random_cmd();
        sparkle_cmd_t c;
        int           pick;
        c.led    = ($urandom_range(99) < 70) ? LED_W'($urandom_range(7)) : LED_W'($urandom);
        c.pslot  = SLOT_W'($urandom);
        c.red    = CHAN_W'($urandom);
        c.green  = CHAN_W'($urandom);
        c.blue   = CHAN_W'($urandom);
        c.rand_a = RAND_W'($urandom);
        c.rand_b = RAND_W'($urandom);
        c.rand_c = RAND_W'($urandom);
        pick = $urandom_range(99);
        if (pick < 5)
            c.delta = '0;
        else if (pick < 10)
            c.delta = '1;
        else if (pick < 75)
            c.delta = DELTA_W'($urandom_range(120));
        else
            c.delta = DELTA_W'($urandom);
        pick = $urandom_range(99);
        if (pick < 8)
            c.op = OP_PAL_WRITE;
        else if (pick < 20)
            c.op = OP_LED_INIT;
        else if (pick < 96)
            c.op = OP_LED_TICK;
        else
            c.op = OP_UNUSED;
        // Seed an LED before its first tick
        if (c.op == OP_LED_TICK && !led_seeded[c.led])
            c.op = OP_LED_INIT;
        return c;
    endfunction

    // Edge cases: full and zero colors, zero and full delta, clamp at full,
    // reseed from an all-ones rand_a and with zero pause, non-positive levels reporting black,
    // and a dropped operation code.
    task automatic queue_directed();
        queue_cmd(fixed_cmd(OP_PAL_WRITE, 6'd0,  4'd0,  24'hFFFFFF, '0, '0, '0, '0));
        queue_cmd(fixed_cmd(OP_PAL_WRITE, 6'd63, 4'd15, 24'h000000, '1, '1, '1, '1));
        queue_cmd(fixed_cmd(OP_PAL_WRITE, 6'd5,  4'd7,  24'hFF8001, 10'd3, 16'h1234,
                            16'h5678, 16'h9ABC));
        // Seed at full brightness, slot 0
        queue_cmd(fixed_cmd(OP_LED_INIT, 6'd0, 4'd3, 24'h123456, 10'd9, 16'h0000,
                            16'h00FF, 16'h0000));
        queue_cmd(fixed_cmd(OP_LED_TICK, 6'd0, 4'd0, 24'h0, 10'd0, '0, '0, '0));
        queue_cmd(fixed_cmd(OP_LED_TICK, 6'd0, 4'd0, 24'h0, 10'd1023, '0, '0, '0));
        queue_cmd(fixed_cmd(OP_LED_TICK, 6'd0, 4'd0, 24'h0, 10'd1023, '0, '0, '0));
        queue_cmd(fixed_cmd(OP_LED_TICK, 6'd0, 4'd0, 24'h0, 10'd1023, '0, '0, '0));
        // Falls below zero: reseed with the pause of an all-ones rand_a into slot 7
        queue_cmd(fixed_cmd(OP_LED_TICK, 6'd0, 4'd0, 24'h0, 10'd1023, 16'hFFFF,
                            16'hFFF7, 16'hFFFF));
        // Lowest seed level, slot 15 (black)
        queue_cmd(fixed_cmd(OP_LED_INIT, 6'd63, 4'd0, 24'h0, '0, 16'h00FF, 16'h0000,
                            16'hFFFF));
        queue_cmd(fixed_cmd(OP_LED_TICK, 6'd63, 4'd15, '1, 10'd1023, '1, '1, '1));
        // Seed at exactly zero, tick with no elapsed time
        queue_cmd(fixed_cmd(OP_LED_INIT, 6'd1, 4'd0, 24'h0, '0, 16'hFF80, 16'h0080,
                            16'h0000));
        queue_cmd(fixed_cmd(OP_LED_TICK, 6'd1, 4'd0, 24'h0, 10'd0, '0, '0, '0));
        queue_cmd(fixed_cmd(OP_UNUSED, 6'd1, 4'd9, '1, '1, '1, '1, '1));
        queue_cmd(fixed_cmd(OP_LED_INIT, 6'd2, 4'd0, 24'h0, '0, 16'hFFFF, 16'hFFFF,
                            16'hFFF7));
        queue_cmd(fixed_cmd(OP_LED_TICK, 6'd2, 4'd0, 24'h0, 10'd50, '0, '0, '0));
        queue_cmd(fixed_cmd(OP_LED_TICK, 6'd2, 4'd0, 24'h0, 10'd1, '0, '0, '0));
        // Reseed with zero pause on a second LED
        queue_cmd(fixed_cmd(OP_LED_INIT, 6'd3, 4'd0, 24'h0, '0, 16'h0000, 16'h00FF,
                            16'h0000));
        queue_cmd(fixed_cmd(OP_LED_TICK, 6'd3, 4'd0, 24'h0, 10'd1023, '0, '0, '0));
        queue_cmd(fixed_cmd(OP_LED_TICK, 6'd3, 4'd0, 24'h0, 10'd1023, 16'd800,
                            16'h0000, '0));
        queue_cmd(fixed_cmd(OP_LED_TICK, 6'd3, 4'd0, 24'h0, 10'd1023, 16'd800,
                            16'h0000, '0));
        queue_cmd(fixed_cmd(OP_LED_TICK, 6'd3, 4'd0, 24'h0, 10'd1023, 16'd800,
                            16'h0000, '0));
    endtask

    // ------------------------------------------------------------------
    // Configuration port: setup cycle, access cycle, changes at falling edge
    // ------------------------------------------------------------------
    task automatic cfg_write(input logic reg_idx, input logic [SPEED_W-1:0] value);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CFG_AW'(4 * reg_idx);
        pwdata  <= CFG_DW'(value);
        @(negedge aclk);
        penable <= 1'b1;
        // The register takes the value at this edge
        @(posedge aclk);
        if (reg_idx == REG_FADE_IN)
            fade_in_now = value;
        else
            fade_out_now = value;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic cfg_check(input logic reg_idx, input logic [SPEED_W-1:0] value);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= CFG_AW'(4 * reg_idx);
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        if (prdata !== CFG_DW'(value)) begin
            $error("register %0d readback: expected %0d, got %0d", reg_idx, value, prdata);
            mismatches++;
        end
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Wait until the block has drained, then let dropped beats clear the pipe
    task automatic wait_idle();
        while (cmd_backlog.size() != 0 || color_reports.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic run_phase(input bit write_cfg, input logic [SPEED_W-1:0] fin,
                             input logic [SPEED_W-1:0] fout, input int send_pct,
                             input int recv_pct, input int n_items);
        sparkle_cmd_t c;
        int           made;
        wait_idle();
        if (write_cfg) begin
            cfg_write(REG_FADE_IN, fin);
            cfg_write(REG_FADE_OUT, fout);
            cfg_check(REG_FADE_IN, fin);
            cfg_check(REG_FADE_OUT, fout);
            n_settings++;
        end
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        made = 0;
        while (made < n_items) begin
            c = random_cmd();
            queue_cmd(c);
            // Dropped codes do not count toward the phase length
            if (c.op != OP_UNUSED)
                made++;
        end
    endtask

    // ------------------------------------------------------------------
    // Stream driver: present the head of the backlog at the falling edge;
    // hold it until the block takes it, and idle at random between beats.
    // ------------------------------------------------------------------
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (s_tvalid && !beat_taken) begin
            // hold the current beat
        end else begin
            beat_taken = 1'b0;
            if (cmd_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                s_tvalid <= 1'b1;
                s_tuser  <= cmd_backlog[0].op;
                s_tdata  <= S_DATA_W'({cmd_backlog[0].rand_c, cmd_backlog[0].rand_b,
                                       cmd_backlog[0].rand_a, cmd_backlog[0].delta,
                                       cmd_backlog[0].blue, cmd_backlog[0].green,
                                       cmd_backlog[0].red, cmd_backlog[0].pslot,
                                       cmd_backlog[0].led});
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Result-side back-pressure
    always @(negedge aclk) begin
        m_tready <= aresetn && ($urandom_range(99) >= recv_idle_pct);
    end

    // ------------------------------------------------------------------
    // Monitor: take input beats into the predictor, check output beats
    // against the oldest owed color, and watch for a stalled block.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : port_monitor
        sparkle_cmd_t  taken;
        color_report_t want;
        color_report_t got;
        if (aresetn && s_tvalid && s_tready) begin
            taken = cmd_backlog.pop_front();
            beat_taken = 1'b1;
            model_fader_beat(taken);
        end
        if (aresetn && m_tvalid && m_tready) begin
            got.led   = m_tdata[5:0];
            got.red   = m_tdata[13:6];
            got.green = m_tdata[21:14];
            got.blue  = m_tdata[29:22];
            if (color_reports.size() == 0) begin
                $error("unexpected color beat for LED %0d", got.led);
                mismatches++;
            end else begin
                want = color_reports.pop_front();
                n_checked++;
                if (got.led !== want.led) begin
                    $error("led_out_index: expected %0d, got %0d", want.led, got.led);
                    mismatches++;
                end
                if (got.red !== want.red) begin
                    $error("out_red: expected %0d, got %0d", want.red, got.red);
                    mismatches++;
                end
                if (got.green !== want.green) begin
                    $error("out_green: expected %0d, got %0d", want.green, got.green);
                    mismatches++;
                end
                if (got.blue !== want.blue) begin
                    $error("out_blue: expected %0d, got %0d", want.blue, got.blue);
                    mismatches++;
                end
            end
        end
        // Count cycles with no beat on either side
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no beat for %0d cycles", WATCHDOG_LIMIT);
            $display("led_sparkle_fader regression: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequence: reset, then phases of speed settings and idle profiles
    // ------------------------------------------------------------------
    initial begin
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Reset speeds first, read back before any write
        cfg_check(REG_FADE_IN, FADE_IN_RESET);
        cfg_check(REG_FADE_OUT, FADE_OUT_RESET);
        send_idle_pct = 12;
        recv_idle_pct = 82;
        queue_directed();
        run_phase(1'b0, '0, '0, 12, 82, 150);
        // Largest fade speeds
        run_phase(1'b1, 8'd255, 8'd255, 12, 82, 150);
        // Frozen fades
        run_phase(1'b1, 8'd0, 8'd0, 82, 12, 100);
        run_phase(1'b1, SPEED_W'($urandom), SPEED_W'($urandom), 82, 12, 150);
        run_phase(1'b1, 8'd1, 8'd255, 0, 0, 150);
        run_phase(1'b1, FADE_IN_RESET, FADE_OUT_RESET, 0, 0, 200);

        // Drain and let trailing beats show up
        while (cmd_backlog.size() != 0 || color_reports.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (color_reports.size() != 0) begin
            $error("%0d color beats never arrived", color_reports.size());
            mismatches++;
        end

        $display("covered %0d input beats: %0d palette writes, %0d seeds, %0d ticks, %0d dropped",
                 n_pal + n_init + n_tick + n_drop, n_pal, n_init, n_tick, n_drop);
        $display("checked %0d color beats: %0d clamps, %0d reseeds, %0d dark, %0d settings",
                 n_checked, n_clamp, n_reseed, n_dark, n_settings);
        if (mismatches == 0) begin
            $display("led_sparkle_fader regression: pass");
        end else begin
            $display("led_sparkle_fader regression: fail");
        end
        $finish;
    end

endmodule
